>>> rtl/core/icmap_pkg.sv
package icmap_pkg;

    // input item kinds, carried in tuser bit 0
    localparam logic CMD_MEASURE = 1'b0;
    localparam logic CMD_COLOR   = 1'b1;

    // configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_ADDR_W-1:0] REG_RAINBOW_MODE   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_INVERT_RAINBOW = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_AUTO_BOUNDS    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_LOW_BOUND      = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_HIGH_BOUND     = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_LOW_COLOR      = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_HIGH_COLOR     = 3'd6;

    localparam int BOUND_W = 24;
    localparam int COLOR_W = 24;
    localparam int CHAN_W  = 8;

    localparam logic signed [BOUND_W-1:0] LOW_BOUND_RST  = 24'sd0;
    localparam logic signed [BOUND_W-1:0] HIGH_BOUND_RST = 24'sd1048576;
    localparam logic [COLOR_W-1:0]        LOW_COLOR_RST  = 24'h000000;
    localparam logic [COLOR_W-1:0]        HIGH_COLOR_RST = 24'hFFFFFF;

    // normalized value q in unsigned Q16, 1.0 is 65536
    localparam int Q_FRAC_BITS = 16;
    localparam int Q_W         = Q_FRAC_BITS + 1;
    localparam logic [Q_W-1:0] Q_ONE = 17'd65536;
    localparam int DIV_CNT_W   = $clog2(Q_FRAC_BITS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_PREP,
        ST_DIVIDE,
        ST_COLOR
    } icmap_state_t;

    typedef struct packed {
        logic measure;   // measure item accepted
        logic load;      // color item accepted, latch sample
        logic setup;     // form numerator and denominator
        logic prep;      // magnitudes, flags, divider init
        logic div_step;  // one quotient bit
        logic emit;      // load output register
    } icmap_cmd_t;

    typedef struct packed {
        logic out_free;  // output register can take a new item
    } icmap_status_t;

endpackage

>>> rtl/core/intensity_to_color_map.sv
// color item: latched on acceptance, then ST_SETUP, ST_PREP, the 16-step restoring
// divider loop in ST_DIVIDE and ST_COLOR; no new item is taken until back in ST_IDLE
// measure item: no result, the next item can be taken in the following cycle
// a waiting result holds the next color result in ST_COLOR, where no item is accepted
// rst_n is asynchronous active low: configuration returns to defaults, running
// bounds to most positive / most negative sample, output register empties
module intensity_to_color_map
    import icmap_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 24
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0]         cfg_addr,
    input  logic [CFG_DATA_W-1:0]         cfg_wdata,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0] s_axis_tdata,  // intensity
    input  logic [1:0]                    s_axis_tuser,  // cmd, first
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [3*CHAN_W-1:0]           m_axis_tdata   // {blue, green, red}
);

    icmap_cmd_t        cmd;
    icmap_status_t     status;
    logic [CHAN_W-1:0] red, green, blue;

    icmap_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_cmd   (s_axis_tuser[0]),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    icmap_datapath #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .in_intensity ($signed(s_axis_tdata[SAMPLE_WIDTH-1:0])),
        .in_first     (s_axis_tuser[1]),
        .cmd          (cmd),
        .status       (status),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_red      (red),
        .out_green    (green),
        .out_blue     (blue)
    );

    assign m_axis_tdata = {blue, green, red};

endmodule

>>> rtl/core/icmap_ctrl.sv
module icmap_ctrl
    import icmap_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          in_cmd,
    output logic          in_ready,
    input  icmap_status_t status,
    output icmap_cmd_t    cmd
);

    icmap_state_t           state_reg, state_next;
    logic [DIV_CNT_W-1:0]   div_cnt_reg, div_cnt_next;
    logic                   accept;
    logic                   div_last;

    assign accept   = in_valid && (state_reg == ST_IDLE);
    assign div_last = (div_cnt_reg == DIV_CNT_W'(Q_FRAC_BITS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            div_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (in_cmd == CMD_COLOR))
                    state_next = ST_SETUP;
            end
            ST_SETUP:  state_next = ST_PREP;
            ST_PREP:   state_next = ST_DIVIDE;
            ST_DIVIDE:
            begin
                if (div_last)
                    state_next = ST_COLOR;
            end
            ST_COLOR:
            begin
                if (status.out_free)
                    state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready     = 1'b0;
        cmd          = '0;
        div_cnt_next = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready     = 1'b1;
                cmd.measure  = accept && (in_cmd == CMD_MEASURE);
                cmd.load     = accept && (in_cmd == CMD_COLOR);
            end
            ST_SETUP:  cmd.setup = 1'b1;
            ST_PREP:   cmd.prep  = 1'b1;
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                div_cnt_next = div_cnt_reg + DIV_CNT_W'(1);
            end
            ST_COLOR:  cmd.emit = status.out_free;
            default:   cmd = '0;
        endcase
    end

endmodule

>>> rtl/core/icmap_datapath.sv
module icmap_datapath
    import icmap_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 24
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0]          cfg_addr,
    input  logic [CFG_DATA_W-1:0]          cfg_wdata,
    input  logic signed [SAMPLE_WIDTH-1:0] in_intensity,
    input  logic                           in_first,
    input  icmap_cmd_t                     cmd,
    output icmap_status_t                  status,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [CHAN_W-1:0]              out_red,
    output logic [CHAN_W-1:0]              out_green,
    output logic [CHAN_W-1:0]              out_blue
);

    localparam int LW = (SAMPLE_WIDTH > BOUND_W) ? SAMPLE_WIDTH : BOUND_W;
    localparam int DW = LW + 1;

    localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    // configuration
    logic                       rainbow_mode_reg;
    logic                       invert_rainbow_reg;
    logic                       auto_bounds_reg;
    logic signed [BOUND_W-1:0]  low_bound_reg;
    logic signed [BOUND_W-1:0]  high_bound_reg;
    logic [COLOR_W-1:0]         low_color_reg;
    logic [COLOR_W-1:0]         high_color_reg;

    logic signed [SAMPLE_WIDTH-1:0] running_min_reg;
    logic signed [SAMPLE_WIDTH-1:0] running_max_reg;

    logic signed [SAMPLE_WIDTH-1:0] sample_reg;
    logic signed [DW-1:0]           num_reg;
    logic signed [DW-1:0]           den_reg;
    logic [DW-1:0]                  rem_reg;
    logic [DW-1:0]                  dsr_reg;
    logic [Q_FRAC_BITS-1:0]         quot_reg;
    logic                           zero_reg;
    logic                           sat_reg;

    logic                           out_valid_reg;
    logic [CHAN_W-1:0]              red_reg, green_reg, blue_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rainbow_mode_reg   <= 1'b1;
            invert_rainbow_reg <= 1'b0;
            auto_bounds_reg    <= 1'b1;
            low_bound_reg      <= LOW_BOUND_RST;
            high_bound_reg     <= HIGH_BOUND_RST;
            low_color_reg      <= LOW_COLOR_RST;
            high_color_reg     <= HIGH_COLOR_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                REG_RAINBOW_MODE:   rainbow_mode_reg   <= cfg_wdata[0];
                REG_INVERT_RAINBOW: invert_rainbow_reg <= cfg_wdata[0];
                REG_AUTO_BOUNDS:    auto_bounds_reg    <= cfg_wdata[0];
                REG_LOW_BOUND:      low_bound_reg      <= $signed(cfg_wdata[BOUND_W-1:0]);
                REG_HIGH_BOUND:     high_bound_reg     <= $signed(cfg_wdata[BOUND_W-1:0]);
                REG_LOW_COLOR:      low_color_reg      <= cfg_wdata[COLOR_W-1:0];
                REG_HIGH_COLOR:     high_color_reg     <= cfg_wdata[COLOR_W-1:0];
                default: ;
            endcase
        end
    end

    // running bounds
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_min_reg <= SAMPLE_MAX;
            running_max_reg <= SAMPLE_MIN;
        end
        else if (cmd.measure)
        begin
            if (in_first)
            begin
                running_min_reg <= in_intensity;
                running_max_reg <= in_intensity;
            end
            else
            begin
                if (in_intensity < running_min_reg)
                    running_min_reg <= in_intensity;
                if (in_intensity > running_max_reg)
                    running_max_reg <= in_intensity;
            end
        end
    end

    // normalization front end
    logic signed [DW-1:0] v_ext, lo_ext, hi_ext;
    logic [DW-1:0]        num_mag, den_mag;
    logic [DW:0]          rem_dbl;
    logic                 rem_ge;
    logic [DW:0]          rem_sub;

    always_comb
    begin
        v_ext   = DW'(sample_reg);
        lo_ext  = auto_bounds_reg ? DW'(running_min_reg) : DW'(low_bound_reg);
        hi_ext  = auto_bounds_reg ? DW'(running_max_reg) : DW'(high_bound_reg);
        num_mag = num_reg[DW-1] ? DW'(-num_reg) : DW'(num_reg);
        den_mag = den_reg[DW-1] ? DW'(-den_reg) : DW'(den_reg);
        rem_dbl = {rem_reg, 1'b0};
        rem_ge  = (rem_dbl >= {1'b0, dsr_reg});
        rem_sub = rem_dbl - {1'b0, dsr_reg};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            sample_reg <= in_intensity;
        if (cmd.setup)
        begin
            num_reg <= v_ext - lo_ext;
            den_reg <= hi_ext - lo_ext;
        end
        if (cmd.prep)
        begin
            // signs differ or either side zero: quotient clamps to zero
            zero_reg <= (den_reg == '0) || (num_reg == '0) ||
                        (num_reg[DW-1] != den_reg[DW-1]);
            sat_reg  <= (num_mag >= den_mag);
            rem_reg  <= num_mag;
            dsr_reg  <= den_mag;
            quot_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg  <= rem_ge ? rem_sub[DW-1:0] : rem_dbl[DW-1:0];
            quot_reg <= {quot_reg[Q_FRAC_BITS-2:0], rem_ge};
        end
    end

    // color back end
    function automatic logic [CHAN_W-1:0] to8(input logic [Q_W-1:0] c);
        logic [24:0] t;
        t = {c, 8'b0} - 25'(c);
        return t[23:16];
    endfunction

    function automatic logic [CHAN_W-1:0] blend(input logic [CHAN_W-1:0] hc,
                                                 input logic [CHAN_W-1:0] lc,
                                                 input logic [Q_W-1:0]    q);
        logic [25:0] s;
        s = 26'(hc) * 26'(q) + 26'(lc) * 26'(Q_ONE - q);
        return s[23:16];
    endfunction

    logic [Q_W-1:0]    q_val, x_val, f_val, n_val;
    logic [18:0]       h_val;
    logic [2:0]        seg;
    logic [Q_W-1:0]    rc, gc, bc;
    logic [CHAN_W-1:0] red_next, green_next, blue_next;

    always_comb
    begin
        if (zero_reg)
            q_val = '0;
        else if (sat_reg)
            q_val = Q_ONE;
        else
            q_val = {1'b0, quot_reg};

        x_val = invert_rainbow_reg ? q_val : (Q_ONE - q_val);
        h_val = ({2'b0, x_val} << 2) + {2'b0, x_val} + 19'(Q_ONE);
        seg   = h_val[18:16];
        f_val = seg[0] ? {1'b0, h_val[15:0]} : (Q_ONE - {1'b0, h_val[15:0]});
        n_val = Q_ONE - f_val;

        if (seg <= 3'd1)
        begin
            rc = n_val;  gc = '0;     bc = Q_ONE;
        end
        else if (seg == 3'd2)
        begin
            rc = '0;     gc = n_val;  bc = Q_ONE;
        end
        else if (seg == 3'd3)
        begin
            rc = '0;     gc = Q_ONE;  bc = n_val;
        end
        else if (seg == 3'd4)
        begin
            rc = n_val;  gc = Q_ONE;  bc = '0;
        end
        else
        begin
            rc = Q_ONE;  gc = n_val;  bc = '0;
        end

        if (rainbow_mode_reg)
        begin
            red_next   = to8(rc);
            green_next = to8(gc);
            blue_next  = to8(bc);
        end
        else
        begin
            red_next   = blend(high_color_reg[23:16], low_color_reg[23:16], q_val);
            green_next = blend(high_color_reg[15:8],  low_color_reg[15:8],  q_val);
            blue_next  = blend(high_color_reg[7:0],   low_color_reg[7:0],   q_val);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign out_red         = red_reg;
    assign out_green       = green_reg;
    assign out_blue        = blue_reg;

endmodule

>>> rtl/core/icmap_checker.sv
module icmap_checker
    import icmap_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                s_axis_tvalid,
    input logic                s_axis_tready,
    input logic [1:0]          s_axis_tuser,
    input logic                m_axis_tvalid,
    input logic                m_axis_tready,
    input logic [3*CHAN_W-1:0] m_axis_tdata
);

    logic in_acc;
    assign in_acc = s_axis_tvalid && s_axis_tready;

    // stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // stalled result keeps its value
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // a measure item never produces a result
    assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && (s_axis_tuser[0] == CMD_MEASURE) && !m_axis_tvalid |=> !m_axis_tvalid)
        else $error("result after measure item");

    // a color item occupies the divider, no new item right after it
    assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && (s_axis_tuser[0] == CMD_COLOR) |=> !s_axis_tready)
        else $error("item taken while divider busy");

    // no result can appear in the cycle after a color item is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && (s_axis_tuser[0] == CMD_COLOR) && !m_axis_tvalid |=> !m_axis_tvalid)
        else $error("result too early");

endmodule

bind intensity_to_color_map icmap_checker u_icmap_checker (.*);

>>> tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
    import icmap_pkg::*;

    localparam int SAMPLE_W = 24;
    localparam int TDATA_W = ((SAMPLE_W + 7) / 8) * 8;
    localparam longint Q1 = 65536;
    localparam int SETTLE_CYCLES = 40;
    localparam longint CYCLE_LIMIT = 600000;
    localparam int RANDOM_ITEMS = 1500;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 3'd7;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    typedef struct packed {
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } rgb_t;

    typedef enum logic [1:0] {
        RX_FREE,
        RX_HALF,
        RX_SPARSE,
        RX_PERIODIC
    } rx_mode_t;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_wr_en;
    logic [CFG_ADDR_W-1:0]    cfg_addr;
    logic [CFG_DATA_W-1:0]    cfg_wdata;
    logic                     s_axis_tvalid;
    logic                     s_axis_tready;
    logic [TDATA_W-1:0]       s_axis_tdata;   // intensity
    logic [1:0]               s_axis_tuser;   // cmd, first
    logic                     m_axis_tvalid;
    logic                     m_axis_tready;
    logic [3*CHAN_W-1:0]      m_axis_tdata;   // {blue, green, red}

    // shadow copy of the block's registers and running bounds
    logic                       map_rainbow;
    logic                       map_invert;
    logic                       map_auto;
    logic signed [BOUND_W-1:0]  map_low_bound;
    logic signed [BOUND_W-1:0]  map_high_bound;
    logic [COLOR_W-1:0]         map_low_color;
    logic [COLOR_W-1:0]         map_high_color;
    logic signed [SAMPLE_W-1:0] run_min;
    logic signed [SAMPLE_W-1:0] run_max;

    rgb_t     pending_rgb[$];
    int       items_sent = 0;
    int       colors_sent = 0;
    int       results_seen = 0;
    int       n_errors = 0;
    int       cfg_phases = 0;
    int       burst_left = 0;
    int       hold_left = 0;
    bit       steady_tx = 0;
    longint   cycle_cnt = 0;
    rx_mode_t rx_mode = RX_FREE;
    int       rx_span = 0;

    intensity_to_color_map #(
        .SAMPLE_WIDTH(SAMPLE_W)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #1 clk = ~clk;

    function automatic logic [CHAN_W-1:0] to_chan(input longint c);
        return CHAN_W'((c * 255) >>> 16);
    endfunction

    function automatic logic [CHAN_W-1:0] blend(input logic [CHAN_W-1:0] hc,
                                                 input logic [CHAN_W-1:0] lc,
                                                 input longint q);
        return CHAN_W'((longint'(hc) * q + longint'(lc) * (Q1 - q)) >>> 16);
    endfunction

    function automatic rgb_t predict_rgb(input logic signed [SAMPLE_W-1:0] value);
        longint lo;
        longint hi;
        longint span;
        longint q;
        longint x;
        longint h;
        longint seg;
        longint frac;
        longint n;
        longint r;
        longint g;
        longint b;
        rgb_t   rgb;
        lo = map_auto ? longint'(run_min) : longint'(map_low_bound);
        hi = map_auto ? longint'(run_max) : longint'(map_high_bound);
        span = hi - lo;
        q = (span == 0) ? 0 : ((longint'(value) - lo) * Q1) / span;
        if (q < 0)
            q = 0;
        if (q > Q1)
            q = Q1;
        if (map_rainbow)
        begin
            x = map_invert ? q : Q1 - q;
            h = 5 * x + Q1;
            seg = h >>> 16;
            frac = h % Q1;
            if (seg % 2 == 0)
                frac = Q1 - frac;
            n = Q1 - frac;
            if (seg <= 1)
            begin
                r = n;  g = 0;  b = Q1;
            end
            else if (seg == 2)
            begin
                r = 0;  g = n;  b = Q1;
            end
            else if (seg == 3)
            begin
                r = 0;  g = Q1; b = n;
            end
            else if (seg == 4)
            begin
                r = n;  g = Q1; b = 0;
            end
            else
            begin
                r = Q1; g = n;  b = 0;
            end
            rgb.red   = to_chan(r);
            rgb.green = to_chan(g);
            rgb.blue  = to_chan(b);
        end
        else
        begin
            rgb.red   = blend(map_high_color[23:16], map_low_color[23:16], q);
            rgb.green = blend(map_high_color[15:8], map_low_color[15:8], q);
            rgb.blue  = blend(map_high_color[7:0], map_low_color[7:0], q);
        end
        return rgb;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] cloud_sample(input longint center,
                                                                input int spread);
        case ($urandom_range(0, 15))
            0:       return SAMPLE_MIN;
            1:       return SAMPLE_MAX;
            2:       return SAMPLE_W'($urandom);
            default: return SAMPLE_W'(center + longint'($urandom_range(0, spread)) - spread / 2);
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        @(posedge clk);
        case (addr)
            REG_RAINBOW_MODE:   map_rainbow = value[0];
            REG_INVERT_RAINBOW: map_invert = value[0];
            REG_AUTO_BOUNDS:    map_auto = value[0];
            REG_LOW_BOUND:      map_low_bound = value;
            REG_HIGH_BOUND:     map_high_bound = value;
            REG_LOW_COLOR:      map_low_color = value;
            REG_HIGH_COLOR:     map_high_color = value;
            default:            ;
        endcase
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_item(input logic cmd, input logic first,
                             input logic signed [SAMPLE_W-1:0] value);
        int gap;
        if (!steady_tx)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 24);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                if (gap > 0)
                begin
                    @(negedge clk);
                    s_axis_tvalid <= 1'b0;
                    repeat (gap - 1) @(negedge clk);
                end
            end
            burst_left--;
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= {first, cmd};
        s_axis_tdata  <= value;
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        items_sent++;
        if (cmd == CMD_MEASURE)
        begin
            if (first)
            begin
                run_min = value;
                run_max = value;
            end
            else
            begin
                if (value < run_min)
                    run_min = value;
                if (value > run_max)
                    run_max = value;
            end
        end
        else
        begin
            pending_rgb.insert(pending_rgb.size(), predict_rgb(value));
            colors_sent++;
        end
    endtask

    // stop offering, let every result drain, then allow for a measure item in flight
    task automatic wait_results();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_rgb.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic random_config();
        logic signed [BOUND_W-1:0] lo_b;
        logic signed [BOUND_W-1:0] hi_b;
        logic [COLOR_W-1:0]        lo_c;
        logic [COLOR_W-1:0]        hi_c;
        case ($urandom_range(0, 4))
            0:
            begin
                lo_b = SAMPLE_MIN;
                hi_b = SAMPLE_MAX;
            end
            1:
            begin
                lo_b = SAMPLE_MAX;
                hi_b = SAMPLE_MIN;
            end
            2:
            begin
                lo_b = run_min;
                hi_b = run_max;
            end
            3:
            begin
                lo_b = BOUND_W'($urandom);
                hi_b = lo_b;
            end
            default:
            begin
                lo_b = BOUND_W'($urandom);
                hi_b = BOUND_W'($urandom);
            end
        endcase
        case ($urandom_range(0, 3))
            0:
            begin
                lo_c = '0;
                hi_c = '1;
            end
            1:
            begin
                lo_c = '1;
                hi_c = '0;
            end
            default:
            begin
                lo_c = COLOR_W'($urandom);
                hi_c = COLOR_W'($urandom);
            end
        endcase
        write_reg(REG_RAINBOW_MODE, CFG_DATA_W'($urandom));
        write_reg(REG_INVERT_RAINBOW, CFG_DATA_W'($urandom));
        write_reg(REG_AUTO_BOUNDS, CFG_DATA_W'($urandom));
        write_reg(REG_LOW_BOUND, lo_b);
        write_reg(REG_HIGH_BOUND, hi_b);
        write_reg(REG_LOW_COLOR, lo_c);
        write_reg(REG_HIGH_COLOR, hi_c);
        if ($urandom_range(0, 7) == 0)
            write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
        cfg_phases++;
    endtask

    // reset bounds give a negative range; the first flag on a color item does nothing
    task automatic test_before_measure();
        send_item(CMD_COLOR, 1'b1, SAMPLE_MIN);
        send_item(CMD_COLOR, 1'b0, SAMPLE_MAX);
        send_item(CMD_COLOR, 1'b1, '0);
    endtask

    task automatic test_extremes();
        send_item(CMD_MEASURE, 1'b1, '0);
        send_item(CMD_MEASURE, 1'b0, SAMPLE_MIN);
        send_item(CMD_MEASURE, 1'b0, SAMPLE_MAX);
        send_item(CMD_COLOR, 1'b0, SAMPLE_MIN);
        send_item(CMD_COLOR, 1'b0, SAMPLE_MAX);
        send_item(CMD_COLOR, 1'b0, '1);
        // one sample inside each rainbow segment
        for (int k = 1; k < 10; k += 2)
            send_item(CMD_COLOR, 1'b0, SAMPLE_W'(longint'(SAMPLE_MIN) + k * 1677722));
    endtask

    task automatic test_zero_range();
        send_item(CMD_MEASURE, 1'b1, 24'sd25600);
        send_item(CMD_COLOR, 1'b0, 24'sd25600);
        send_item(CMD_COLOR, 1'b0, -24'sd76800);
    endtask

    task automatic test_ramp_and_bounds();
        wait_results();
        write_reg(REG_RAINBOW_MODE, '0);
        write_reg(REG_AUTO_BOUNDS, '0);
        write_reg(REG_LOW_COLOR, 24'h123456);
        write_reg(REG_HIGH_COLOR, 24'hFEDCBA);
        write_reg(REG_LOW_BOUND, -24'sd1000);
        write_reg(REG_HIGH_BOUND, 24'sd1000);
        send_item(CMD_COLOR, 1'b0, -24'sd1000);
        send_item(CMD_COLOR, 1'b0, 24'sd1);
        send_item(CMD_COLOR, 1'b0, 24'sd5000);
        wait_results();
        // reversed range
        write_reg(REG_LOW_BOUND, 24'sd1000);
        write_reg(REG_HIGH_BOUND, -24'sd1000);
        send_item(CMD_COLOR, 1'b0, -24'sd2000);
        send_item(CMD_COLOR, 1'b0, 24'sd300);
        wait_results();
        write_reg(REG_RAINBOW_MODE, 24'h000001);
        write_reg(REG_INVERT_RAINBOW, 24'h000001);
        write_reg(REG_UNUSED, 24'hFFFFFF);
        send_item(CMD_COLOR, 1'b0, 24'sd700);
        send_item(CMD_COLOR, 1'b0, -24'sd700);
        cfg_phases += 3;
    endtask

    // receiver holds off while the sender keeps pushing, then the results drain
    task automatic test_hold_off();
        wait_results();
        hold_left = HOLD_OFF_CYCLES;
        steady_tx = 1;
        for (int k = 0; k < 30; k++)
            send_item(($urandom_range(0, 2) != 0) ? CMD_COLOR : CMD_MEASURE, k == 0,
                      SAMPLE_W'($urandom));
        steady_tx = 0;
        wait_results();
    endtask

    task automatic test_random_clouds();
        logic signed [SAMPLE_W-1:0] cloud[$];
        int     sent;
        int     size;
        int     spread;
        longint center;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                wait_results();
                random_config();
            end
            steady_tx = ($urandom_range(0, 3) == 0);
            size = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 60)
                                               : $urandom_range(1, 16);
            spread = 1 << $urandom_range(0, 22);
            center = longint'(SAMPLE_MIN) + longint'($urandom_range(0, 32'hFFFFFF));
            cloud.delete();
            for (int k = 0; k < size; k++)
                cloud.insert(cloud.size(), cloud_sample(center, spread));
            // most clouds are measured first; some skip it and reuse old bounds
            if ($urandom_range(0, 9) != 0)
            begin
                foreach (cloud[k])
                begin
                    send_item(CMD_MEASURE, (k == 0) || ($urandom_range(0, 31) == 0),
                              cloud[k]);
                    sent++;
                end
            end
            foreach (cloud[k])
            begin
                if ($urandom_range(0, 15) == 0)
                    send_item(logic'($urandom_range(0, 1)), logic'($urandom_range(0, 1)),
                              SAMPLE_W'($urandom));
                else
                    send_item(CMD_COLOR, ($urandom_range(0, 7) == 0), cloud[k]);
                sent++;
            end
        end
        steady_tx = 0;
    endtask

    // receiver stall pattern, a new mode is drawn whenever the current span runs out
    always @(negedge clk)
    begin
        if (rx_span == 0)
        begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_span = $urandom_range(16, 120);
        end
        rx_span--;
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            case (rx_mode)
                RX_FREE:     m_axis_tready <= 1'b1;
                RX_HALF:     m_axis_tready <= logic'($urandom_range(0, 1));
                RX_SPARSE:   m_axis_tready <= ($urandom_range(0, 3) == 0);
                default:     m_axis_tready <= ((rx_span % 4) != 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        rgb_t got;
        rgb_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = rgb_t'(m_axis_tdata);
            if (pending_rgb.size() == 0)
            begin
                $display("%0t: result %h with no item pending", $time, m_axis_tdata);
                n_errors++;
            end
            else
            begin
                want = pending_rgb.pop_front();
                results_seen++;
                if (got.red !== want.red)
                begin
                    $display("%0t: red mismatch, expected %0d, actual %0d",
                             $time, want.red, got.red);
                    n_errors++;
                end
                if (got.green !== want.green)
                begin
                    $display("%0t: green mismatch, expected %0d, actual %0d",
                             $time, want.green, got.green);
                    n_errors++;
                end
                if (got.blue !== want.blue)
                begin
                    $display("%0t: blue mismatch, expected %0d, actual %0d",
                             $time, want.blue, got.blue);
                    n_errors++;
                end
            end
        end
    end

    initial
    begin
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("timeout after %0d cycles", cycle_cnt);
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_addr      = '0;
        cfg_wdata     = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        map_rainbow    = 1'b1;
        map_invert     = 1'b0;
        map_auto       = 1'b1;
        map_low_bound  = LOW_BOUND_RST;
        map_high_bound = HIGH_BOUND_RST;
        map_low_color  = LOW_COLOR_RST;
        map_high_color = HIGH_COLOR_RST;
        run_min        = SAMPLE_MAX;
        run_max        = SAMPLE_MIN;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_before_measure();
        test_extremes();
        test_zero_range();
        test_ramp_and_bounds();
        test_hold_off();
        test_random_clouds();
        wait_results();

        $display("sent %0d items, %0d color results checked of %0d predicted",
                 items_sent, results_seen, colors_sent);
        $display("%0d register settings, one long output hold-off, %0d mismatches",
                 cfg_phases, n_errors);
        if (n_errors == 0 && pending_rgb.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
